FILE: hdl/stsm_pkg.sv
// Package: shared constants, types and config register codes of the sparse template sum matcher.
package stsm_pkg;

    localparam int IMAGE_WIDTH   = 2048;
    localparam int HISTORY_DEPTH = 16384;   // power of two
    localparam int MAX_POINTS    = 5;

    localparam int OFFSET_REGS  = 5;
    localparam int NUM_TAPS     = (MAX_POINTS < OFFSET_REGS) ? MAX_POINTS : OFFSET_REGS;
    localparam int SEARCH_LIMIT = 2048;

    localparam int PIX_W    = 8;
    localparam int OFF_W    = 14;
    localparam int CNT_W    = 3;
    localparam int SEARCH_W = 12;
    localparam int SUM_W    = 11;
    localparam int COORD_W  = 11;

    localparam int COL_W  = $clog2(IMAGE_WIDTH);
    localparam int IDX_W  = $clog2(SEARCH_LIMIT * IMAGE_WIDTH) + 1;
    localparam int ROW_W  = IDX_W - COL_W;
    localparam int ADDR_W = $clog2(HISTORY_DEPTH);

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 14;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = QPTR_W + 1;

    localparam int OUT_FIELDS_W = SUM_W + 2 * COORD_W;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TEMPLATE_COUNT = 4'd0,
        CFG_OFFSET_0       = 4'd1,
        CFG_OFFSET_1       = 4'd2,
        CFG_OFFSET_2       = 4'd3,
        CFG_OFFSET_3       = 4'd4,
        CFG_OFFSET_4       = 4'd5,
        CFG_SEARCH_WIDTH   = 4'd6,
        CFG_SEARCH_HEIGHT  = 4'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [CNT_W-1:0]                points;
        logic [OFF_W-1:0]                largest;
        logic [NUM_TAPS-1:0][OFF_W-1:0]  delta;
        logic [SEARCH_W-1:0]             sw;
        logic [SEARCH_W-1:0]             sh;
    } t_cfg;

    typedef struct packed {
        logic [NUM_TAPS-1:0][PIX_W-1:0]  taps;
        logic [COORD_W-1:0]              col;
        logic [COORD_W-1:0]              row;
        logic                            last;
    } t_item;

    typedef struct packed {
        logic [QCNT_W-1:0] count;
        logic              empty;
    } t_qstat;

endpackage

FILE: hdl/stsm_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered read data.
module stsm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16384
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/stsm_front.sv
// Front end: pixel index, base classification, history write and parallel tap reads.
module stsm_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  stsm_pkg::t_cfg              i_cfg,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [stsm_pkg::PIX_W-1:0]  i_pixel,
    input  logic                        i_frame_start,
    input  stsm_pkg::t_qstat            i_qstat,
    output logic                        o_push,
    output stsm_pkg::t_item             o_item
);

    import stsm_pkg::*;

    logic                           w_accept;
    logic [IDX_W-1:0]               r_idx;
    logic [IDX_W-1:0]               n_idx;
    logic [IDX_W-1:0]               w_p;
    logic [IDX_W-1:0]               w_b;
    logic                           w_ge;
    logic [COL_W-1:0]               w_col;
    logic [ROW_W-1:0]               w_row;
    logic                           w_hit;
    logic                           w_last;
    logic [NUM_TAPS-1:0][ADDR_W-1:0] w_raddr;
    logic [NUM_TAPS-1:0][PIX_W-1:0] w_rdata;
    logic [NUM_TAPS-1:0]            w_byp;
    logic [NUM_TAPS-1:0]            w_use;

    logic                           r_s1_valid;
    logic [PIX_W-1:0]               r_pix;
    logic [NUM_TAPS-1:0]            r_byp;
    logic [NUM_TAPS-1:0]            r_use;
    logic [COORD_W-1:0]             r_col;
    logic [COORD_W-1:0]             r_row;
    logic                           r_last;

    // room in the queue for everything already in flight
    assign o_ready  = ({1'b0, i_qstat.count} + {{QCNT_W{1'b0}}, r_s1_valid})
                      < (QCNT_W+1)'(QDEPTH);
    assign w_accept = i_valid & o_ready;

    assign w_p   = i_frame_start ? '0 : r_idx;
    assign n_idx = (&w_p) ? w_p : w_p + IDX_W'(1);

    assign w_ge  = w_p >= IDX_W'(i_cfg.largest);
    assign w_b   = w_p - IDX_W'(i_cfg.largest);
    assign w_col = w_b[COL_W-1:0];
    assign w_row = w_b[IDX_W-1:COL_W];

    assign w_hit  = w_ge && (IDX_W'(w_col) < IDX_W'(i_cfg.sw))
                         && (IDX_W'(w_row) < IDX_W'(i_cfg.sh));
    assign w_last = (IDX_W'(w_col) + IDX_W'(1) == IDX_W'(i_cfg.sw))
                 && (IDX_W'(w_row) + IDX_W'(1) == IDX_W'(i_cfg.sh));

    for (genvar g = 0; g < NUM_TAPS; g++) begin : g_tap
        // tap address = base + offset = index - (largest - offset)
        assign w_raddr[g] = w_p[ADDR_W-1:0] - ADDR_W'(i_cfg.delta[g]);
        assign w_byp[g]   = ADDR_W'(i_cfg.delta[g]) == '0;
        assign w_use[g]   = i_cfg.points > CNT_W'(g);

        stsm_ram #(
            .WIDTH (PIX_W),
            .DEPTH (HISTORY_DEPTH)
        ) u_hist (
            .i_clk   (i_clk),
            .i_we    (w_accept),
            .i_waddr (w_p[ADDR_W-1:0]),
            .i_wdata (i_pixel),
            .i_re    (w_accept),
            .i_raddr (w_raddr[g]),
            .o_rdata (w_rdata[g])
        );

        assign o_item.taps[g] = r_use[g] ? (r_byp[g] ? r_pix : w_rdata[g]) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= w_accept & w_hit;
            if (w_accept) begin
                r_idx <= n_idx;
            end
        end
        if (w_accept) begin
            r_pix  <= i_pixel;
            r_byp  <= w_byp;
            r_use  <= w_use;
            r_col  <= COORD_W'(w_col);
            r_row  <= COORD_W'(w_row);
            r_last <= w_last;
        end
    end

    assign o_push      = r_s1_valid;
    assign o_item.col  = r_col;
    assign o_item.row  = r_row;
    assign o_item.last = r_last;

endmodule

FILE: hdl/stsm_queue.sv
// Short FIFO of tap sets between the front end and the back end.
module stsm_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  stsm_pkg::t_item   i_item,
    input  logic              i_pop,
    output stsm_pkg::t_item   o_item,
    output stsm_pkg::t_qstat  o_stat
);

    import stsm_pkg::*;

    t_item             r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QCNT_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rptr <= r_rptr + QPTR_W'(1);
            end
            r_count <= r_count + QCNT_W'(i_push) - QCNT_W'(i_pop);
        end
        if (i_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

    assign o_item       = r_mem[r_rptr];
    assign o_stat.count = r_count;
    assign o_stat.empty = r_count == '0;

endmodule

FILE: hdl/stsm_back.sv
// Back end: sums the taps of one base and holds the result in the output register.
module stsm_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  stsm_pkg::t_item                   i_item,
    input  stsm_pkg::t_qstat                  i_qstat,
    output logic                              o_pop,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [stsm_pkg::OUT_DATA_W-1:0]   o_m_tdata,
    output logic                              o_m_tlast
);

    import stsm_pkg::*;

    localparam int PAD_W = OUT_DATA_W - OUT_FIELDS_W;

    logic [SUM_W-1:0]   w_sum;
    logic               r_valid;
    logic [SUM_W-1:0]   r_sum;
    logic [COORD_W-1:0] r_col;
    logic [COORD_W-1:0] r_row;
    logic               r_last;

    always_comb begin
        w_sum = '0;
        for (int k = 0; k < NUM_TAPS; k++) begin
            w_sum = w_sum + SUM_W'(i_item.taps[k]);
        end
    end

    assign o_pop = !i_qstat.empty && (!r_valid || i_m_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_valid <= 1'b0;
        end
        if (o_pop) begin
            r_sum  <= w_sum;
            r_col  <= i_item.col;
            r_row  <= i_item.row;
            r_last <= i_item.last;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = {{PAD_W{1'b0}}, r_row, r_col, r_sum};
    assign o_m_tlast  = r_last;

endmodule

FILE: hdl/sparse_template_sum_matcher_top.sv
// Top level of the sparse template sum matcher: config registers, front end, queue, back end.
//
// Usage:
//   Slave stream: one 8-bit pixel per transaction in raster order, 2048 pixels per row.
//   tuser high marks the first pixel of a frame and restarts the pixel index.
//   Master stream: one transaction per base inside the search area, carrying the sum of
//   the pixels at the configured offsets plus the base column and row; tlast flags the
//   final base. A base is reported with the pixel at base plus the largest offset.
//   Config channel: index/data writes, always ready; write only while the block is idle.
//   Throughput: one pixel per clock while the slave tready is high; the five tap reads go to
//   five history RAM copies in parallel, each written with every pixel.
//   Path: an accepted pixel passes the tap read registers, the queue and the output
//   register in turn before its result is valid on the master stream.
//   Stall: a four-entry queue and the output register absorb a stalled receiver; the
//   slave tready drops only when the queue plus the in-flight stage would be full.
//   Reset: pixel index 0, registers back to five points, offsets 0, 2048 x 2048 search
//   area; the history RAM is not cleared, entries are only used after being written.
module sparse_template_sum_matcher_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [stsm_pkg::PIX_W-1:0]        i_s_tdata,   // [7:0] pixel
    input  logic                              i_s_tuser,   // [0] frame_start
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [stsm_pkg::OUT_DATA_W-1:0]   o_m_tdata,   // [10:0] match_sum, [21:11] base_col,
                                                           // [32:22] base_row, rest zero
    output logic                              o_m_tlast,   // last_base
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [stsm_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [stsm_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    import stsm_pkg::*;

    logic                          w_cfg_we;
    logic [CNT_W-1:0]              r_count;
    logic [CNT_W-1:0]              n_count;
    logic [OFFSET_REGS-1:0][OFF_W-1:0] r_offset;
    logic [OFFSET_REGS-1:0][OFF_W-1:0] n_offset;
    logic [SEARCH_W-1:0]           r_sw;
    logic [SEARCH_W-1:0]           n_sw;
    logic [SEARCH_W-1:0]           r_sh;
    logic [SEARCH_W-1:0]           n_sh;
    logic [SEARCH_W-1:0]           w_search;
    t_cfg                          r_cfg;
    t_cfg                          n_cfg;

    logic                          w_push;
    logic                          w_pop;
    t_item                         w_front_item;
    t_item                         w_head_item;
    t_qstat                        w_qstat;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_we    = i_cfg_valid & o_cfg_ready;
    assign w_search    = (i_cfg_data[SEARCH_W-1:0] > SEARCH_W'(SEARCH_LIMIT))
                         ? SEARCH_W'(SEARCH_LIMIT) : i_cfg_data[SEARCH_W-1:0];

    always_comb begin
        n_count  = r_count;
        n_offset = r_offset;
        n_sw     = r_sw;
        n_sh     = r_sh;
        if (w_cfg_we) begin
            unique case (i_cfg_index)
                CFG_TEMPLATE_COUNT: n_count     = i_cfg_data[CNT_W-1:0];
                CFG_OFFSET_0:       n_offset[0] = i_cfg_data[OFF_W-1:0];
                CFG_OFFSET_1:       n_offset[1] = i_cfg_data[OFF_W-1:0];
                CFG_OFFSET_2:       n_offset[2] = i_cfg_data[OFF_W-1:0];
                CFG_OFFSET_3:       n_offset[3] = i_cfg_data[OFF_W-1:0];
                CFG_OFFSET_4:       n_offset[4] = i_cfg_data[OFF_W-1:0];
                CFG_SEARCH_WIDTH:   n_sw        = w_search;
                CFG_SEARCH_HEIGHT:  n_sh        = w_search;
                default:            n_count     = r_count;
            endcase
        end
    end

    // derived setup, registered together with the write
    always_comb begin
        n_cfg.points  = (n_count > CNT_W'(NUM_TAPS)) ? CNT_W'(NUM_TAPS) : n_count;
        n_cfg.largest = '0;
        for (int k = 0; k < NUM_TAPS; k++) begin
            if ((n_cfg.points > CNT_W'(k)) && (n_offset[k] > n_cfg.largest)) begin
                n_cfg.largest = n_offset[k];
            end
        end
        for (int k = 0; k < NUM_TAPS; k++) begin
            n_cfg.delta[k] = n_cfg.largest - n_offset[k];
        end
        n_cfg.sw = n_sw;
        n_cfg.sh = n_sh;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count       <= CNT_W'(5);
            r_offset      <= '0;
            r_sw          <= SEARCH_W'(SEARCH_LIMIT);
            r_sh          <= SEARCH_W'(SEARCH_LIMIT);
            r_cfg.points  <= CNT_W'(NUM_TAPS);
            r_cfg.largest <= '0;
            r_cfg.delta   <= '0;
            r_cfg.sw      <= SEARCH_W'(SEARCH_LIMIT);
            r_cfg.sh      <= SEARCH_W'(SEARCH_LIMIT);
        end else begin
            r_count  <= n_count;
            r_offset <= n_offset;
            r_sw     <= n_sw;
            r_sh     <= n_sh;
            r_cfg    <= n_cfg;
        end
    end

    stsm_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_valid       (i_s_tvalid),
        .o_ready       (o_s_tready),
        .i_pixel       (i_s_tdata),
        .i_frame_start (i_s_tuser),
        .i_qstat       (w_qstat),
        .o_push        (w_push),
        .o_item        (w_front_item)
    );

    stsm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .i_pop   (w_pop),
        .o_item  (w_head_item),
        .o_stat  (w_qstat)
    );

    stsm_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (w_head_item),
        .i_qstat    (w_qstat),
        .o_pop      (w_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && (w_qstat.count == QCNT_W'(QDEPTH))) |-> w_pop)
        else $error("queue push while full");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_qstat.count <= QCNT_W'(QDEPTH))
        else $error("queue count out of range");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_qstat.empty)
        else $error("queue pop while empty");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");
`endif

endmodule
